>>> sv/rocal_pkg.sv
// Package for the rotor offset calibration averager.
// Shared widths, constants, register codes and structs; no dependencies.

package rocal_pkg;

  // Field widths
  localparam int DEG_W   = 9;
  localparam int WIDTH_W = 14;
  localparam int DIR_W   = 2;
  localparam int CFG_W   = 14;

  // Sweep constants (degrees)
  localparam logic [DEG_W-1:0] SWEEP_STEP = DEG_W'(10);
  localparam logic [DEG_W-1:0] SWEEP_MAX  = DEG_W'(359);
  localparam int               MAX_DIFF   = 350;

  // Default window depth of the difference ring
  localparam int WINDOW_DEPTH_DEF = 100;

  // Register reset values
  localparam logic [WIDTH_W-1:0] DRIVE_WIDTH_RST = WIDTH_W'(9000);
  localparam logic [DIR_W-1:0]   DRIVE_DIR_RST   = DIR_W'(1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CALIB_ENABLE    = 2'd0,
    CFG_DRIVE_WIDTH     = 2'd1,
    CFG_DRIVE_DIRECTION = 2'd2
  } cfg_idx_t;

  // Result of the sweep step for one item
  typedef struct packed {
    logic [DEG_W-1:0] angle;
    logic             taken;
    logic [DEG_W-1:0] diff;
  } sweep_res_t;

endpackage

>>> sv/rocal_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on rocal_pkg for field widths.

interface rocal_in_if;
  logic                        valid;
  logic                        ready;
  logic [rocal_pkg::DEG_W-1:0] measured_degree;

  modport source(output valid, output measured_degree, input ready);
  modport sink(input valid, input measured_degree, output ready);
endinterface

interface rocal_out_if;
  logic                          valid;
  logic                          ready;
  logic [rocal_pkg::DEG_W-1:0]   drive_angle;
  logic [rocal_pkg::WIDTH_W-1:0] out_width;
  logic [rocal_pkg::DIR_W-1:0]   out_direction;
  logic [rocal_pkg::DEG_W-1:0]   average_offset;
  logic                          sample_taken;

  modport source(output valid, output drive_angle, output out_width,
                 output out_direction, output average_offset,
                 output sample_taken, input ready);
  modport sink(input valid, input drive_angle, input out_width,
               input out_direction, input average_offset,
               input sample_taken, output ready);
endinterface

>>> sv/rocal_sweep.sv
// Sweep angle generator and ring write index.
// Depends on rocal_pkg; holds calib_enable, phase, sweep angle, ring index.

module rocal_sweep #(
  parameter int WINDOW_DEPTH = rocal_pkg::WINDOW_DEPTH_DEF,
  localparam int IDX_W = $clog2(WINDOW_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        enable_wr,
  input  logic                        enable_val,
  input  logic                        accept,
  input  logic [rocal_pkg::DEG_W-1:0] measured,
  output rocal_pkg::sweep_res_t       res,
  output logic [IDX_W-1:0]            idx_next
);

  logic                        calib_enable;
  logic                        phase;
  logic                        phase_next;
  logic [rocal_pkg::DEG_W-1:0] sweep_angle;
  logic [rocal_pkg::DEG_W-1:0] sweep_next;
  logic [rocal_pkg::DEG_W-1:0] stepped;
  logic [IDX_W-1:0]            ring_index;

  // Next phase and angle for this item
  always_comb begin
    stepped    = sweep_angle + rocal_pkg::SWEEP_STEP;
    phase_next = 1'b0;
    sweep_next = '0;
    if (calib_enable) begin
      if (phase) begin
        phase_next = 1'b0;
        sweep_next = (stepped > rocal_pkg::SWEEP_MAX) ? '0 : stepped;
      end else begin
        phase_next = 1'b1;
        sweep_next = sweep_angle;
      end
    end
    res.angle = sweep_next;
    res.taken = calib_enable && (sweep_next > measured);
    res.diff  = sweep_next - measured;
    idx_next  = (ring_index == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ring_index + 1'b1;
  end

  // State registers; a write of one to calib_enable restarts the angle
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_enable <= 1'b0;
      phase        <= 1'b0;
      sweep_angle  <= '0;
      ring_index   <= '0;
    end else if (enable_wr) begin
      calib_enable <= enable_val;
      if (enable_val) begin
        sweep_angle <= '0;
      end
    end else if (accept) begin
      phase       <= phase_next;
      sweep_angle <= sweep_next;
      if (res.taken) begin
        ring_index <= idx_next;
      end
    end
  end

endmodule

>>> sv/rocal_ring.sv
// Difference ring: one write and one registered read per cycle.
// Depends on rocal_pkg; entries read as zero until written after reset.

module rocal_ring #(
  parameter int WINDOW_DEPTH = rocal_pkg::WINDOW_DEPTH_DEF,
  localparam int IDX_W = $clog2(WINDOW_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [rocal_pkg::DEG_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [rocal_pkg::DEG_W-1:0] wr_data
);

  logic [rocal_pkg::DEG_W-1:0] mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]     written;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Read port, with bypass of a write to the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (written[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

>>> sv/rocal_div.sv
// Divide-by-window stage: multiply by a fixed reciprocal, then shift.
// Depends on rocal_pkg; one registered multiply, quotient is a bit slice.

module rocal_div #(
  parameter int WINDOW_DEPTH = rocal_pkg::WINDOW_DEPTH_DEF,
  parameter int SUM_W = 16
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [SUM_W-1:0]            sum,
  output logic [rocal_pkg::DEG_W-1:0] quotient
);

  // floor(n / D) == (n * ceil(2^K / D)) >> K for all n < 2^SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W   = SUM_W + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam int PROD_W    = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));
    end
  end

  assign quotient = prod[DIV_SHIFT +: rocal_pkg::DEG_W];

endmodule

>>> sv/rotor_offset_calibration_averager.sv
// Top level of the rotor offset calibration averager.
// Depends on rocal_pkg, rocal_if, rocal_sweep, rocal_ring and rocal_div.
//
// Use: one input item per control tick on sample_in carries the measured
// electrical angle. Each item gives exactly one result item on result_out:
// the forced drive angle, the width and direction registers, the averaged
// offset and a flag that a difference was stored this tick.
// Configuration is written through cfg_we / cfg_index / cfg_data while no
// item is in flight: calib_enable (0), drive_width (1), drive_direction (2).
// Pipeline: three register stages (ring read at accept, sum update with write
// back and reciprocal multiply, output reg), passed by each item in that order.
// Throughput: one item per cycle while result_out is not stalled; the ring memory
// has one read and one write port, and the running sum is updated once per item.
// Reset (rst, synchronous): registers to their reset values, sweep idle,
// the ring reads as all zero through per-entry valid bits; no clearing pass.
// Stall: each stage holds while the next is full and stalled; empty stages
// still fill, so up to three items are held before sample_in.ready drops.

module rotor_offset_calibration_averager #(
  parameter int WINDOW_DEPTH = rocal_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rocal_pkg::CFG_W-1:0]   cfg_data,
  rocal_in_if.sink                      sample_in,
  rocal_out_if.source                   result_out
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = $clog2(WINDOW_DEPTH * rocal_pkg::MAX_DIFF + 1);

  // Configuration registers
  logic [rocal_pkg::WIDTH_W-1:0] drive_width;
  logic [rocal_pkg::DIR_W-1:0]   drive_direction;
  logic                          enable_wr;

  assign enable_wr = cfg_we && (cfg_index == rocal_pkg::CFG_CALIB_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_width     <= rocal_pkg::DRIVE_WIDTH_RST;
      drive_direction <= rocal_pkg::DRIVE_DIR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rocal_pkg::CFG_DRIVE_WIDTH:     drive_width     <= cfg_data;
        rocal_pkg::CFG_DRIVE_DIRECTION: drive_direction <= cfg_data[rocal_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic accept;

  assign en3    = !v3 || result_out.ready;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign accept = sample_in.valid && en1;
  assign sample_in.ready = en1;

  // Sweep step at accept
  rocal_pkg::sweep_res_t sres;
  logic [IDX_W-1:0]      idx_next;

  rocal_sweep #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_sweep (
    .clk        (clk),
    .rst        (rst),
    .enable_wr  (enable_wr),
    .enable_val (cfg_data[0]),
    .accept     (accept),
    .measured   (sample_in.measured_degree),
    .res        (sres),
    .idx_next   (idx_next)
  );

  // Stage 1 registers: ring entry is being read
  logic [rocal_pkg::DEG_W-1:0]   angle1;
  logic [rocal_pkg::WIDTH_W-1:0] width1;
  logic [rocal_pkg::DIR_W-1:0]   dir1;
  logic                          taken1;
  logic [rocal_pkg::DEG_W-1:0]   diff1;
  logic [IDX_W-1:0]              idx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      angle1 <= sres.angle;
      width1 <= drive_width;
      dir1   <= drive_direction;
      taken1 <= sres.taken;
      diff1  <= sres.diff;
      idx1   <= idx_next;
    end
  end

  // Ring memory: read at accept, written back as stage 1 moves on
  logic                        ring_wr;
  logic [rocal_pkg::DEG_W-1:0] old_diff;

  assign ring_wr = v1 && en2 && taken1;

  rocal_ring #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (idx_next),
    .rd_data (old_diff),
    .wr_en   (ring_wr),
    .wr_addr (idx1),
    .wr_data (diff1)
  );

  // Running sum of the ring
  logic [SUM_W-1:0] ring_sum;
  logic [SUM_W-1:0] ring_sum_next;

  assign ring_sum_next = taken1 ?
    SUM_W'(ring_sum - SUM_W'(old_diff) + SUM_W'(diff1)) : ring_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_sum <= '0;
    end else if (v1 && en2) begin
      ring_sum <= ring_sum_next;
    end
  end

  // Stage 2 registers: multiply by the window reciprocal
  logic [rocal_pkg::DEG_W-1:0]   angle2;
  logic [rocal_pkg::WIDTH_W-1:0] width2;
  logic [rocal_pkg::DIR_W-1:0]   dir2;
  logic                          taken2;
  logic [rocal_pkg::DEG_W-1:0]   quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && en2) begin
      angle2 <= angle1;
      width2 <= width1;
      dir2   <= dir1;
      taken2 <= taken1;
    end
  end

  rocal_div #(.WINDOW_DEPTH(WINDOW_DEPTH), .SUM_W(SUM_W)) u_div (
    .clk      (clk),
    .load     (v1 && en2),
    .sum      (ring_sum_next),
    .quotient (quotient)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && en3) begin
      result_out.drive_angle    <= angle2;
      result_out.out_width      <= width2;
      result_out.out_direction  <= dir2;
      result_out.average_offset <= quotient;
      result_out.sample_taken   <= taken2;
    end
  end

  assign result_out.valid = v3;

`ifndef SYNTH
  // A stored difference needs a nonzero drive angle
  a_taken_angle: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.sample_taken |-> result_out.drive_angle != '0)
    else $error("sample taken with zero drive angle");

  // The average cannot exceed the largest difference
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.average_offset <= rocal_pkg::DEG_W'(rocal_pkg::MAX_DIFF))
    else $error("average offset out of range");

  // Running sum stays within the window bound
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> 32'(ring_sum) <= 32'(WINDOW_DEPTH * rocal_pkg::MAX_DIFF))
    else $error("ring sum exceeds window bound");

  // Input is refused only while the output is held by the receiver
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !sample_in.ready |-> result_out.valid && !result_out.ready)
    else $error("input stalled without output back-pressure");
`endif

endmodule
